// ===== rtl/twcf_pkg.sv =====
package twcf_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);

  localparam logic [7:0] TAG_WORD      = 8'd2;
  localparam logic [7:0] TOKEN_RELEASE = 8'd1;
  localparam int         WORD_SLOTS    = 5;

  typedef enum logic [1:0] {
    ACT_PUT_TOKEN = 2'd0,
    ACT_PUT_WORD  = 2'd1,
    ACT_GET_TOKEN = 2'd2,
    ACT_GET_WORD  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_OWNED   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  sender;
    logic [7:0]  token_in;
    logic [31:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  token_out;
    logic [31:0] word_out;
    logic        word_valid;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage

// ===== rtl/token_word_channel_fifo_unit.sv =====
// Channel  Direction  Payload                                 Handshake
// in_      input      action, sender, token_in, word_in       in_valid / in_stall
// out_     output     status, token_out, word_out, word_valid out_valid / out_stall
//
// One request in flight; a put or get of a word moves it one byte per
// cycle through the single-port byte ring, whose read data is registered.
// Reset: rst_n synchronous; clears pointers, owner, sequencer state and the output valid flag.
// Ring contents are not cleared.
// A new word is taken once the previous result sits in the output register;
// out_stall only holds that register and the sequencer's finished result.
module token_word_channel_fifo_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  twcf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output twcf_pkg::out_word_t out_data
);

  twcf_pkg::mem_req_t  mem_req;
  logic [7:0]          mem_rdata;
  logic                busy;
  logic                res_valid;
  logic                res_ready;
  twcf_pkg::out_word_t res;

  logic                out_valid_r;
  twcf_pkg::out_word_t out_data_r;

  // byte ring storage
  twcf_ram #(
    .DATA_W (8),
    .ADDR_W (twcf_pkg::PTR_W),
    .WORDS  (twcf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // put/get sequencer: pointers, owner, byte-serial word framing
  twcf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item       (in_data),
    .busy       (busy),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  assign in_stall  = busy;

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // an accepted word always keeps the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer idle right after accept");

  // a handed-over result shows up at the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid)
    else $error("result lost on hand-over");

  // a delivered word only comes with a done status
  a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.word_valid |-> out_data.status == twcf_pkg::ST_DONE)
    else $error("word_valid with non-done status");
`endif

endmodule

// ===== rtl/twcf_ram.sv =====
module twcf_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8,
  parameter int WORDS  = 256
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/twcf_ctrl.sv =====
module twcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  twcf_pkg::in_word_t  item,
  output logic                busy,
  output twcf_pkg::mem_req_t  mem_req,
  input  logic [7:0]          mem_rdata,
  output logic                res_valid,
  output twcf_pkg::out_word_t res,
  input  logic                res_ready
);

  localparam int PW = twcf_pkg::PTR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT_WORD,
    S_GET_HEAD,
    S_GET_WORD,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [4:0]    owner_r, owner_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [1:0]    act_r, act_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    tok_r, tok_nxt;
  logic          valid_r, valid_nxt;

  logic [PW-1:0] held;
  logic [4:0]    me;
  logic          accept;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    adv = (p == PW'(twcf_pkg::DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // occupancy, modulo DEPTH
  assign held   = wp_r - rp_r + ((wp_r < rp_r) ? PW'(twcf_pkg::DEPTH) : '0);
  assign me     = {1'b0, item.sender} + 5'd1;
  assign busy   = (state_r != S_IDLE);
  assign accept = item_valid && !busy;

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    p_nxt      = p_r;
    owner_nxt  = owner_r;
    cnt_nxt    = cnt_r;
    act_nxt    = act_r;
    word_nxt   = word_r;
    status_nxt = status_r;
    tok_nxt    = tok_r;
    valid_nxt  = valid_r;
    mem_req    = '{we: 1'b0, addr: rp_r, wdata: 8'd0};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt    = item.action;
          word_nxt   = item.word_in;
          status_nxt = twcf_pkg::ST_DONE;
          tok_nxt    = 8'd0;
          valid_nxt  = 1'b0;
          cnt_nxt    = 2'd0;
          state_nxt  = S_DONE;
          if (item.action == twcf_pkg::ACT_PUT_TOKEN ||
              item.action == twcf_pkg::ACT_PUT_WORD) begin
            if (owner_r != 5'd0 && owner_r != me) begin
              status_nxt = twcf_pkg::ST_OWNED;
            end else begin
              owner_nxt = me;  // taken before the room test
              if (item.action == twcf_pkg::ACT_PUT_TOKEN) begin
                if (held != PW'(twcf_pkg::DEPTH - 1)) begin
                  mem_req = '{we: 1'b1, addr: wp_r, wdata: item.token_in};
                  wp_nxt  = adv(wp_r);
                  if (item.token_in == twcf_pkg::TOKEN_RELEASE) begin
                    owner_nxt = 5'd0;
                  end
                end else begin
                  status_nxt = twcf_pkg::ST_NO_ROOM;
                end
              end else begin
                if (held <= PW'(twcf_pkg::DEPTH - 1 - twcf_pkg::WORD_SLOTS)) begin
                  mem_req   = '{we: 1'b1, addr: wp_r, wdata: twcf_pkg::TAG_WORD};
                  wp_nxt    = adv(wp_r);
                  state_nxt = S_PUT_WORD;
                end else begin
                  status_nxt = twcf_pkg::ST_NO_ROOM;
                end
              end
            end
          end else if (held == '0) begin
            status_nxt = twcf_pkg::ST_EMPTY;
          end else begin
            mem_req   = '{we: 1'b0, addr: rp_r, wdata: 8'd0};
            p_nxt     = adv(rp_r);
            state_nxt = S_GET_HEAD;
          end
        end
      end

      S_PUT_WORD: begin
        mem_req  = '{we: 1'b1, addr: wp_r, wdata: word_r[7:0]};
        wp_nxt   = adv(wp_r);
        word_nxt = {8'd0, word_r[31:8]};
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end

      S_GET_HEAD: begin
        tok_nxt   = mem_rdata;
        state_nxt = S_DONE;
        // prefetch first word byte; harmless if unused
        mem_req   = '{we: 1'b0, addr: p_r, wdata: 8'd0};
        if (act_r == twcf_pkg::ACT_GET_TOKEN) begin
          if (mem_rdata != twcf_pkg::TAG_WORD) begin
            rp_nxt = p_r;
          end
        end else if (mem_rdata == twcf_pkg::TAG_WORD) begin
          if (held < PW'(twcf_pkg::WORD_SLOTS)) begin
            status_nxt = twcf_pkg::ST_EMPTY;
          end else begin
            p_nxt     = adv(p_r);
            state_nxt = S_GET_WORD;
          end
        end
      end

      S_GET_WORD: begin
        mem_req  = '{we: 1'b0, addr: p_r, wdata: 8'd0};
        word_nxt = {mem_rdata, word_r[31:8]};
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          rp_nxt    = p_r;
          valid_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          p_nxt = adv(p_r);
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      owner_r <= 5'd0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      owner_r <= owner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    act_r    <= act_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
    tok_r    <= tok_nxt;
    valid_r  <= valid_nxt;
  end

  assign res_valid      = (state_r == S_DONE);
  assign res.status     = status_r;
  assign res.token_out  = tok_r;
  assign res.word_out   = valid_r ? word_r : 32'd0;
  assign res.word_valid = valid_r;

endmodule
